// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/ssrw_pkg.sv =====
// types, constants and helpers for the spi slave register window
package ssrw_pkg;

   localparam int NUM_WINDOWS  = 8;
   localparam int WINDOW_BYTES = 16;
   localparam int STORE_DEPTH  = NUM_WINDOWS * WINDOW_BYTES;
   localparam int WIN_W        = 3;
   localparam int OFS_W        = 4;
   localparam int ADDR_W       = WIN_W + OFS_W;
   localparam int LEN_W        = 5;
   localparam int LENGTHS_W    = 8 * LEN_W;
   localparam int COUNT_W      = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;

   localparam logic [COUNT_W-1:0]   WINDOW_COUNT_RST   = COUNT_W'(8);
   localparam logic [LENGTHS_W-1:0] WINDOW_LENGTHS_RST = '0;

   typedef enum logic [2:0] {
      OP_FRAME_START = 3'd0,
      OP_BYTE_RX     = 3'd1,
      OP_TX_REQ      = 3'd2,
      OP_LOCAL_RD    = 3'd3,
      OP_LOCAL_WR    = 3'd4
   } opcode_type;

   // register select is paddr bit 3 (byte address 8*i)
   typedef enum logic {
      REG_WINDOW_COUNT   = 1'b0,
      REG_WINDOW_LENGTHS = 1'b1
   } reg_sel_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wr_data;
   } store_req_type;

   function automatic logic [LEN_W-1:0] win_len(logic [LENGTHS_W-1:0] lengths,
                                                logic [WIN_W-1:0] w);
      logic [LEN_W-1:0] len;
      len = lengths[LEN_W*w +: LEN_W];
      if (len > LEN_W'(WINDOW_BYTES)) begin
         len = LEN_W'(WINDOW_BYTES);
      end
      return len;
   endfunction

endpackage

// ===== hw/rtl/ssrw_store.sv =====
// byte store with per-entry valid bits and a registered read port
`include "assert_macros.svh"
module ssrw_store (
   input  logic                          clock,
   input  logic                          reset,
   input  ssrw_pkg::store_req_type       req,
   output logic [7:0]                    rd_data
);

   logic [7:0]                       mem [ssrw_pkg::STORE_DEPTH];
   logic [ssrw_pkg::STORE_DEPTH-1:0] valid_ff;
   logic [ssrw_pkg::STORE_DEPTH-1:0] valid_in;
   logic [7:0]                       rd_data_ff;
   logic                             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

   `ASSERT_CLK(a_no_rd_wr_same_cycle, clock, reset, !(req.wr_en && req.rd_en))
   `ASSERT_CLK(a_wr_sets_valid, clock, reset, req.wr_en |=> valid_ff[$past(req.addr)])
   `ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> (valid_ff == '0))

endmodule

// ===== hw/rtl/spi_slave_register_window.sv =====
// spi_slave_register_window: spi slave register window, top level
// One beat is accepted per clock cycle, back to back, while the result side
// does not stall; each result beat passes the store read stage, then the output
// register, and the output register lets the next request enter while a
// result still waits. The rate is set by the single port of the 128-byte
// store, which takes one read or one write per cycle. The store reads as zero
// after reset through per-entry valid bits, so there is no clearing pass.
`include "assert_macros.svh"
module spi_slave_register_window (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata = spi_byte[7:0], local_window[10:8], local_offset[14:11],
   // local_data[22:15], zero fill; tuser = opcode[2:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,
   input  logic [2:0]                         req_tuser,
   // response: tdata = out_byte[7:0], byte_stored[8], in_window[9], zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssrw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ssrw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssrw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [ssrw_pkg::COUNT_W-1:0]   window_count_ff;
   logic [ssrw_pkg::LENGTHS_W-1:0] window_lengths_ff;

   logic [1:0]                   frame_count_ff, frame_count_in;
   logic                         write_mode_ff, write_mode_in;
   logic [ssrw_pkg::WIN_W-1:0]   sel_window_ff, sel_window_in;
   logic [7:0]                   byte_offset_ff, byte_offset_in;
   logic                         offset_valid_ff, offset_valid_in;

   logic                         s1_valid_ff;
   logic                         s1_from_mem_ff, s1_from_mem_in;
   logic                         s1_stored_ff, s1_stored_in;
   logic                         s1_in_window_ff, s1_in_window_in;
   logic                         s1_spi_data_ff, s1_spi_data_in;

   logic                         rsp_valid_ff;
   logic [15:0]                  rsp_data_ff;

   logic                         req_fire;
   logic                         s1_go;
   logic                         is_header;
   logic                         cursor_ok;
   logic [1:0]                   count_next;
   logic [6:0]                   hdr_idx;
   logic [7:0]                   store_rd_data;
   logic [7:0]                   out_byte;
   ssrw_pkg::store_req_type      store_req;

   logic [7:0]                   spi_byte;
   logic [ssrw_pkg::WIN_W-1:0]   local_window;
   logic [ssrw_pkg::OFS_W-1:0]   local_offset;
   logic [7:0]                   local_data;

   assign spi_byte     = req_tdata[7:0];
   assign local_window = req_tdata[10:8];
   assign local_offset = req_tdata[14:11];
   assign local_data   = req_tdata[22:15];

   // configuration port
   assign csr_pready = 1'b1;

   always_comb begin
      case (ssrw_pkg::reg_sel_type'(csr_paddr[3]))
         ssrw_pkg::REG_WINDOW_COUNT: begin
            csr_prdata = {{(ssrw_pkg::CSR_DATA_W-ssrw_pkg::COUNT_W){1'b0}}, window_count_ff};
         end
         ssrw_pkg::REG_WINDOW_LENGTHS: begin
            csr_prdata = {{(ssrw_pkg::CSR_DATA_W-ssrw_pkg::LENGTHS_W){1'b0}},
                          window_lengths_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff   <= ssrw_pkg::WINDOW_COUNT_RST;
         window_lengths_ff <= ssrw_pkg::WINDOW_LENGTHS_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (ssrw_pkg::reg_sel_type'(csr_paddr[3]))
            ssrw_pkg::REG_WINDOW_COUNT: begin
               window_count_ff <= csr_pwdata[ssrw_pkg::COUNT_W-1:0];
            end
            ssrw_pkg::REG_WINDOW_LENGTHS: begin
               window_lengths_ff <= csr_pwdata[ssrw_pkg::LENGTHS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   assign count_next = (frame_count_ff == 2'd3) ? 2'd3 : frame_count_ff + 2'd1;
   assign cursor_ok  = offset_valid_ff &&
      (byte_offset_ff < {3'b000, ssrw_pkg::win_len(window_lengths_ff, sel_window_ff)});
   assign hdr_idx    = spi_byte[6:0];

   // request decode and control state update
   always_comb begin
      frame_count_in  = frame_count_ff;
      write_mode_in   = write_mode_ff;
      sel_window_in   = sel_window_ff;
      byte_offset_in  = byte_offset_ff;
      offset_valid_in = offset_valid_ff;
      s1_from_mem_in  = 1'b0;
      s1_stored_in    = 1'b0;
      s1_in_window_in = 1'b0;
      s1_spi_data_in  = 1'b0;
      is_header       = 1'b0;
      store_req       = '0;
      store_req.addr  = {sel_window_ff, byte_offset_ff[ssrw_pkg::OFS_W-1:0]};
      store_req.wr_data = spi_byte;
      case (ssrw_pkg::opcode_type'(req_tuser))
         ssrw_pkg::OP_FRAME_START: begin
            frame_count_in = 2'd0;
         end
         ssrw_pkg::OP_BYTE_RX: begin
            frame_count_in = count_next;
            if (count_next == 2'd1) begin
               is_header       = 1'b1;
               write_mode_in   = spi_byte[7];
               offset_valid_in = 1'b0;
               if (hdr_idx >= {3'b000, window_count_ff} ||
                   hdr_idx >= 7'(ssrw_pkg::NUM_WINDOWS)) begin
                  sel_window_in = '0;
               end else begin
                  sel_window_in = hdr_idx[ssrw_pkg::WIN_W-1:0];
               end
            end else if (count_next == 2'd2) begin
               byte_offset_in  = spi_byte;
               offset_valid_in = 1'b1;
            end else begin
               s1_in_window_in = cursor_ok;
               s1_spi_data_in  = 1'b1;
               if (cursor_ok && write_mode_ff) begin
                  store_req.wr_en = 1'b1;
                  byte_offset_in  = byte_offset_ff + 8'd1;
                  s1_stored_in    = 1'b1;
               end
            end
         end
         ssrw_pkg::OP_TX_REQ: begin
            s1_in_window_in = cursor_ok;
            if (cursor_ok && !write_mode_ff) begin
               store_req.rd_en = 1'b1;
               byte_offset_in  = byte_offset_ff + 8'd1;
               s1_from_mem_in  = 1'b1;
            end
         end
         ssrw_pkg::OP_LOCAL_RD: begin
            s1_in_window_in = {1'b0, local_offset} <
               ssrw_pkg::win_len(window_lengths_ff, local_window);
            store_req.addr  = {local_window, local_offset};
            store_req.rd_en = 1'b1;
            s1_from_mem_in  = 1'b1;
         end
         ssrw_pkg::OP_LOCAL_WR: begin
            s1_in_window_in   = {1'b0, local_offset} <
               ssrw_pkg::win_len(window_lengths_ff, local_window);
            store_req.addr    = {local_window, local_offset};
            store_req.wr_data = local_data;
            store_req.wr_en   = 1'b1;
            s1_stored_in      = 1'b1;
         end
         default: begin
         end
      endcase
      if (!req_fire) begin
         store_req.wr_en = 1'b0;
         store_req.rd_en = 1'b0;
      end
   end

   ssrw_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= 2'd0;
         write_mode_ff   <= 1'b0;
         sel_window_ff   <= '0;
         byte_offset_ff  <= 8'd0;
         offset_valid_ff <= 1'b0;
      end else if (req_fire) begin
         frame_count_ff  <= frame_count_in;
         write_mode_ff   <= write_mode_in;
         sel_window_ff   <= sel_window_in;
         byte_offset_ff  <= byte_offset_in;
         offset_valid_ff <= offset_valid_in;
      end
   end

   // store read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_from_mem_ff  <= s1_from_mem_in;
         s1_stored_ff    <= s1_stored_in;
         s1_in_window_ff <= s1_in_window_in;
         s1_spi_data_ff  <= s1_spi_data_in;
      end
   end

   assign out_byte = s1_from_mem_ff ? store_rd_data : 8'd0;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= {6'd0, s1_in_window_ff, s1_stored_ff, out_byte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_CLK(a_spi_store_in_window, clock, reset, (s1_valid_ff && s1_spi_data_ff && s1_stored_ff) |-> s1_in_window_ff)
   `ASSERT_CLK(a_byte_moves_count, clock, reset, (req_fire && req_tuser == ssrw_pkg::OP_BYTE_RX) |=> (frame_count_ff != 2'd0))
   `ASSERT_CLK(a_offset_clear_by_header, clock, reset, $fell(offset_valid_ff) |-> $past(req_fire && is_header))
   `ASSERT_CLK(a_stored_not_read, clock, reset, s1_valid_ff |-> !(s1_stored_ff && s1_from_mem_ff))
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !s1_valid_ff |-> req_tready)

endmodule

// ===== tb/sv/spi_slave_register_window_test.sv =====
// self-checking testbench for the spi slave register window: stream, csr and scoreboard
module spi_slave_register_window_test;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] spi_byte;
      logic [2:0] lwin;
      logic [3:0] lofs;
      logic [7:0] ldata;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       stored;
      logic       in_win;
   } rsp_beat_type;

   class window_scoreboard;
      logic [7:0]                     store [ssrw_pkg::STORE_DEPTH];
      logic [1:0]                     byte_count;
      logic                           write_mode;
      logic [ssrw_pkg::WIN_W-1:0]     sel_win;
      logic [7:0]                     offset;
      logic                           offset_set;
      logic [ssrw_pkg::COUNT_W-1:0]   win_count;
      logic [ssrw_pkg::LENGTHS_W-1:0] win_lengths;
      rsp_beat_type                   reply_queue [$];
      int                             errors;

      function new();
         foreach (store[i]) store[i] = 8'h00;
         byte_count  = '0;
         write_mode  = 1'b0;
         sel_win     = '0;
         offset      = '0;
         offset_set  = 1'b0;
         win_count   = ssrw_pkg::WINDOW_COUNT_RST;
         win_lengths = ssrw_pkg::WINDOW_LENGTHS_RST;
         errors      = 0;
      endfunction

      function void set_register(ssrw_pkg::reg_sel_type sel, logic [63:0] value);
         if (sel == ssrw_pkg::REG_WINDOW_COUNT) begin
            win_count = value[ssrw_pkg::COUNT_W-1:0];
         end else begin
            win_lengths = value[ssrw_pkg::LENGTHS_W-1:0];
         end
      endfunction

      function int length_of(logic [ssrw_pkg::WIN_W-1:0] w);
         int len;
         len = int'((win_lengths >> (ssrw_pkg::LEN_W * int'(w))) & 40'd31);
         if (len > ssrw_pkg::WINDOW_BYTES) len = ssrw_pkg::WINDOW_BYTES;
         return len;
      endfunction

      function rsp_beat_type apply_request(req_beat_type r);
         rsp_beat_type o;
         int           cnt;
         int           addr;
         logic [6:0]   idx;
         bit           ok;
         o = '0;
         case (r.op)
            ssrw_pkg::OP_FRAME_START: byte_count = '0;
            ssrw_pkg::OP_BYTE_RX: begin
               if (byte_count < 2'd3) byte_count = byte_count + 2'd1;
               if (byte_count == 2'd1) begin
                  cnt = (int'(win_count) > ssrw_pkg::NUM_WINDOWS) ? ssrw_pkg::NUM_WINDOWS
                                                                  : int'(win_count);
                  idx = r.spi_byte[6:0];
                  if (int'(idx) >= cnt) idx = '0;
                  write_mode = r.spi_byte[7];
                  sel_win    = idx[ssrw_pkg::WIN_W-1:0];
                  offset_set = 1'b0;
               end else if (byte_count == 2'd2) begin
                  offset     = r.spi_byte;
                  offset_set = 1'b1;
               end else begin
                  ok = offset_set && (int'(offset) < length_of(sel_win));
                  o.in_win = ok;
                  if (ok && write_mode) begin
                     addr = int'(sel_win) * ssrw_pkg::WINDOW_BYTES + int'(offset);
                     store[addr] = r.spi_byte;
                     offset   = offset + 8'd1;
                     o.stored = 1'b1;
                  end
               end
            end
            ssrw_pkg::OP_TX_REQ: begin
               ok = offset_set && (int'(offset) < length_of(sel_win));
               o.in_win = ok;
               if (ok && !write_mode) begin
                  addr = int'(sel_win) * ssrw_pkg::WINDOW_BYTES + int'(offset);
                  o.out_byte = store[addr];
                  offset     = offset + 8'd1;
               end
            end
            ssrw_pkg::OP_LOCAL_RD, ssrw_pkg::OP_LOCAL_WR: begin
               o.in_win = int'(r.lofs) < length_of(r.lwin);
               if (int'(r.lwin) < ssrw_pkg::NUM_WINDOWS &&
                   int'(r.lofs) < ssrw_pkg::WINDOW_BYTES) begin
                  addr = int'(r.lwin) * ssrw_pkg::WINDOW_BYTES + int'(r.lofs);
                  if (r.op == ssrw_pkg::OP_LOCAL_RD) begin
                     o.out_byte = store[addr];
                  end else begin
                     store[addr] = r.ldata;
                     o.stored    = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_request(req_beat_type r);
         reply_queue.push_back(apply_request(r));
      endfunction

      function void check_response(logic [15:0] d);
         rsp_beat_type want;
         rsp_beat_type got;
         got.out_byte = d[7:0];
         got.stored   = d[8];
         got.in_win   = d[9];
         if (reply_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: tdata %h", d);
            return;
         end
         want = reply_queue.pop_front();
         if (got.out_byte !== want.out_byte || got.stored !== want.stored ||
             got.in_win !== want.in_win) begin
            errors++;
            if (errors <= 10) begin
               $display({"mismatch: out_byte exp %h got %h, byte_stored exp %b got %b,",
                         " in_window exp %b got %b"},
                        want.out_byte, got.out_byte, want.stored, got.stored,
                        want.in_win, got.in_win);
            end
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [23:0]                     req_tdata   = '0;  // spi_byte, local_window, local_offset, local_data
   logic [2:0]                      req_tuser   = '0;  // opcode
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [15:0]                     rsp_tdata;         // out_byte, byte_stored, in_window
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [ssrw_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [ssrw_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [ssrw_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   window_scoreboard sb;
   int               beats_sent = 0;
   bit               send_calm  = 0;

   spi_slave_register_window dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic req_beat_type make_beat(logic [2:0] op, logic [7:0] b);
      req_beat_type x;
      x.op       = op;
      x.spi_byte = b;
      x.lwin     = 3'($urandom);
      x.lofs     = 4'($urandom);
      x.ldata    = 8'($urandom);
      return x;
   endfunction

   // result side: random stalls, with quiet stretches of steady ready
   initial begin
      int stall;
      int ticks;
      stall = 0;
      ticks = 0;
      forever begin
         @(posedge clock);
         ticks++;
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_response(rsp_tdata);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            stall = ((ticks / 300) % 4 == 0) ? 0 : pick_gap();
            if (stall > 0) begin
               stall--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic send_beat(req_beat_type b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= b.op;
      req_tdata  <= {1'b0, b.ldata, b.lofs, b.lwin, b.spi_byte};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(b);
      if (b.op <= ssrw_pkg::OP_LOCAL_WR) beats_sent++;
      gap = send_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_local(logic [2:0] op, logic [2:0] w, logic [3:0] ofs,
                             logic [7:0] d);
      req_beat_type x;
      x = make_beat(op, 8'($urandom));
      x.lwin  = w;
      x.lofs  = ofs;
      x.ldata = d;
      send_beat(x);
   endtask

   task automatic send_frame();
      bit         wr;
      int         idx;
      int         n;
      int         r;
      logic [7:0] ofs;
      send_calm = ($urandom_range(0, 4) == 0);
      wr  = 1'($urandom);
      idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : $urandom_range(0, 127);
      ofs = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 17)) : 8'($urandom);
      n   = $urandom_range(0, 18);
      if ($urandom_range(0, 9) != 0) begin
         send_beat(make_beat(ssrw_pkg::OP_FRAME_START, 8'($urandom)));
      end
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, {wr, 7'(idx)}));
      if ($urandom_range(0, 19) != 0) send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, ofs));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            send_beat(make_beat(wr ? ssrw_pkg::OP_BYTE_RX : ssrw_pkg::OP_TX_REQ,
                                8'($urandom)));
         end else if (r < 92) begin
            send_beat(make_beat(wr ? ssrw_pkg::OP_TX_REQ : ssrw_pkg::OP_BYTE_RX,
                                8'($urandom)));
         end else begin
            send_beat(make_beat(3'($urandom_range(ssrw_pkg::OP_FRAME_START, OP_UNUSED_HI)),
                                8'($urandom)));
         end
      end
   endtask

   task automatic run_random(int n);
      int start;
      int r;
      start = beats_sent;
      while (beats_sent - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_frame();
         end else if (r < 90) begin
            send_calm = 0;
            send_local(($urandom_range(0, 1) != 0) ? ssrw_pkg::OP_LOCAL_WR
                                                   : ssrw_pkg::OP_LOCAL_RD,
                       3'($urandom), 4'($urandom), 8'($urandom));
         end else begin
            send_calm = 0;
            send_beat(make_beat(3'($urandom_range(ssrw_pkg::OP_FRAME_START, OP_UNUSED_HI)),
                                8'($urandom)));
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.reply_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(ssrw_pkg::reg_sel_type sel, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(sel, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [ssrw_pkg::COUNT_W-1:0] count,
                            logic [ssrw_pkg::LENGTHS_W-1:0] lengths);
      logic [63:0] v;
      drain();
      v = {$urandom, $urandom};
      v[ssrw_pkg::COUNT_W-1:0] = count;
      csr_write(ssrw_pkg::REG_WINDOW_COUNT, v);
      v = {$urandom, $urandom};
      v[ssrw_pkg::LENGTHS_W-1:0] = lengths;
      csr_write(ssrw_pkg::REG_WINDOW_LENGTHS, v);
   endtask

   task automatic run_directed();
      send_calm = 0;
      send_local(ssrw_pkg::OP_LOCAL_WR, 3'd0, 4'd0, 8'hFF);
      send_local(ssrw_pkg::OP_LOCAL_WR, 3'd7, 4'd15, 8'hA5);
      send_local(ssrw_pkg::OP_LOCAL_RD, 3'd7, 4'd15, 8'h00);
      send_local(ssrw_pkg::OP_LOCAL_RD, 3'd5, 4'd3, 8'hFF);
      send_local(ssrw_pkg::OP_LOCAL_RD, 3'd0, 4'd0, 8'h00);
      // write frame that runs past the end of window 1
      send_beat(make_beat(ssrw_pkg::OP_FRAME_START, 8'h00));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h81));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h02));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h11));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h22));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h33));
      send_beat(make_beat(ssrw_pkg::OP_TX_REQ, 8'hFF));
      // read it back, with a data byte ignored in the read frame
      send_beat(make_beat(ssrw_pkg::OP_FRAME_START, 8'hFF));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h01));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h02));
      send_beat(make_beat(ssrw_pkg::OP_TX_REQ, 8'h00));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h55));
      send_beat(make_beat(ssrw_pkg::OP_TX_REQ, 8'h00));
      send_beat(make_beat(ssrw_pkg::OP_TX_REQ, 8'h00));
      // window index out of range, offset at maximum
      send_beat(make_beat(ssrw_pkg::OP_FRAME_START, 8'h00));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'h7F));
      send_beat(make_beat(ssrw_pkg::OP_BYTE_RX, 8'hFF));
      send_beat(make_beat(ssrw_pkg::OP_TX_REQ, 8'h00));
      for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++) begin
         send_beat('{3'(u), 8'hFF, 3'h7, 4'hF, 8'hFF});
      end
      send_local(ssrw_pkg::OP_LOCAL_WR, 3'd0, 4'd15, 8'h00);
   endtask

   initial begin
      logic [ssrw_pkg::LENGTHS_W-1:0] lens;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_random(40);
      configure(4'd8, {5'd31, 5'd16, 5'd0, 5'd1, 5'd15, 5'd16, 5'd4, 5'd16});
      run_directed();
      run_random(150);
      configure(4'd1, {8{5'd16}});
      run_random(120);
      configure(4'd0, {8{5'd31}});
      run_random(100);
      configure(4'd15, {8{5'd0}});
      run_random(60);
      configure(4'd4, {8{5'd31}});
      run_random(120);
      repeat (3) begin
         for (int w = 0; w < 8; w++) begin
            lens[ssrw_pkg::LEN_W*w +: ssrw_pkg::LEN_W] =
               ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
         end
         configure(4'($urandom), lens);
         run_random(150);
      end
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.reply_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
